// ===== src/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the Huffman code builder and encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

   localparam int NUM_SYM          = 256;
   localparam int NUM_NODE         = 511;
   localparam int SYM_BITS         = 8;
   localparam int NODE_BITS        = 9;
   localparam int HEAP_BITS        = 8;
   localparam int LEN_BITS         = 8;
   localparam int CODE_BITS        = 48;
   localparam int OUT_LEN_BITS     = 6;
   localparam int LC_BITS          = 9;
   localparam int DEF_COUNT_BITS   = 24;
   localparam int DEF_MAX_CODE_LEN = 48;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_COUNT  = 2'd1,
      OP_BUILD  = 2'd2,
      OP_ENCODE = 2'd3
   } op_type;

endpackage

`default_nettype wire

// ===== src/hcb_if.sv =====
// ----------------------------------------------------------------------------
// hcb_req_if / hcb_rsp_if
// Valid/ready channels for requests and results of the code builder.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcb_req_if;
   import hcb_pkg::*;
   logic                valid;
   logic                ready;
   op_type              op;
   logic [SYM_BITS-1:0] symbol;
   modport source (output valid, output op, output symbol, input ready);
   modport sink (input valid, input op, input symbol, output ready);
endinterface

interface hcb_rsp_if;
   import hcb_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CODE_BITS-1:0]    code;
   logic [OUT_LEN_BITS-1:0] code_length;
   logic                    found;
   logic [LC_BITS-1:0]      leaf_count;
   modport source (output valid, output code, output code_length, output found,
                   output leaf_count, input ready);
   modport sink (input valid, input code, input code_length, input found,
                 input leaf_count, output ready);
endinterface

`default_nettype wire

// ===== src/hcb_ram.sv =====
// ----------------------------------------------------------------------------
// hcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/huffman_code_builder_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder_encoder_unit
// Clears and counts bytes, builds a Huffman code via a heap in RAM, encodes bytes.
// ----------------------------------------------------------------------------
// Clear, count and encode give one result each; count reads then writes the count RAM.
// Build: a sequencer heaps the nonzero counts, merges the two lightest nodes until
//   one is left, then walks the tree from the root and fills the code table.
// Throughput: one request at a time; the next is taken once the sequencer idles and the output can take a result.
// Reset: counts zero and every code absent, through valid bits cleared at once.
`default_nettype none

module huffman_code_builder_encoder_unit #(
   parameter int COUNT_BITS   = hcb_pkg::DEF_COUNT_BITS,
   parameter int MAX_CODE_LEN = hcb_pkg::DEF_MAX_CODE_LEN
) (
   input wire logic clock,
   input wire logic reset,
   hcb_req_if.sink  req_chan,
   hcb_rsp_if.source rsp_chan
);

   import hcb_pkg::*;

   localparam int WW     = COUNT_BITS + SYM_BITS;
   localparam int WALK_W = LEN_BITS + MAX_CODE_LEN;

   typedef enum logic [32:0] {
      S_IDLE    = 33'd1 << 0,  S_CLR     = 33'd1 << 1,  S_CNT_RD  = 33'd1 << 2,
      S_CNT_WR  = 33'd1 << 3,  S_ENC_RD  = 33'd1 << 4,  S_ENC_OUT = 33'd1 << 5,
      S_SCAN_RD = 33'd1 << 6,  S_SCAN_CK = 33'd1 << 7,  S_NEXT    = 33'd1 << 8,
      S_P_CHK   = 33'd1 << 9,  S_P_RDH   = 33'd1 << 10, S_P_RDW   = 33'd1 << 11,
      S_MERGE   = 33'd1 << 12, S_Q_RD0   = 33'd1 << 13, S_Q_TOP   = 33'd1 << 14,
      S_Q_LAST  = 33'd1 << 15, S_Q_LASTW = 33'd1 << 16, S_D_CHK   = 33'd1 << 17,
      S_D_RDL   = 33'd1 << 18, S_D_RDLW  = 33'd1 << 19, S_D_RDR   = 33'd1 << 20,
      S_D_RDRW  = 33'd1 << 21, S_D_MOVE  = 33'd1 << 22, S_Q_DONE  = 33'd1 << 23,
      S_M_RDA   = 33'd1 << 24, S_M_WA    = 33'd1 << 25, S_M_WB    = 33'd1 << 26,
      S_W_INIT  = 33'd1 << 27, S_W_CHK   = 33'd1 << 28, S_W_RD    = 33'd1 << 29,
      S_W_WR2   = 33'd1 << 30, S_T_CHK   = 33'd1 << 31, S_T_WR    = 33'd1 << 32
   } state_type;

   state_type              state_ff, state_in;
   logic [SYM_BITS-1:0]    sym_ff, sym_in;
   logic [NODE_BITS-1:0]   i_ff, i_in, leaves_ff, leaves_in, size_ff, size_in;
   logic [NODE_BITS-1:0]   next_ff, next_in, n_ff, n_in, a_ff, a_in, b_ff, b_in;
   logic [NODE_BITS-1:0]   cand_ff, cand_in, selnode_ff, selnode_in, wr_ff, wr_in;
   logic [WW-1:0]          wn_ff, wn_in, selw_ff, selw_in;
   logic [HEAP_BITS-1:0]   pos_ff, pos_in, selpos_ff, selpos_in;
   logic                   sel_ff, sel_in, second_ff, second_in, phase_ff, phase_in;
   logic [LEN_BITS-1:0]    wlen_ff, wlen_in;
   logic [MAX_CODE_LEN-1:0] wcode_ff, wcode_in;
   logic [NUM_SYM-1:0]     cnt_vld_ff, cnt_vld_in, tab_vld_ff, tab_vld_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS-1:0]    rsp_code_ff, rsp_code_in;
   logic [OUT_LEN_BITS-1:0] rsp_len_ff, rsp_len_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [LC_BITS-1:0]      rsp_lc_ff, rsp_lc_in;

   logic                   cnt_we;
   logic [SYM_BITS-1:0]    cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0]  cnt_wdata, cnt_rdata;
   logic                   heap_we;
   logic [HEAP_BITS-1:0]   heap_waddr, heap_raddr;
   logic [NODE_BITS-1:0]   heap_wdata, heap_rdata;
   logic                   wgt_we;
   logic [NODE_BITS-1:0]   wgt_waddr, wgt_raddr;
   logic [WW-1:0]          wgt_wdata, wgt_rdata;
   logic                   kids_we;
   logic [NODE_BITS-1:0]   kids_waddr, kids_raddr;
   logic [2*NODE_BITS-1:0] kids_wdata, kids_rdata;
   logic                   lsym_we;
   logic [HEAP_BITS-1:0]   lsym_waddr, lsym_raddr;
   logic [SYM_BITS-1:0]    lsym_wdata, lsym_rdata;
   logic                   walk_we;
   logic [NODE_BITS-1:0]   walk_waddr, walk_raddr;
   logic [WALK_W-1:0]      walk_wdata, walk_rdata;
   logic                   tab_we;
   logic [SYM_BITS-1:0]    tab_waddr, tab_raddr;
   logic [WALK_W-1:0]      tab_wdata, tab_rdata;

   logic                   req_fire;
   logic [SYM_BITS-1:0]    scan_sym;
   logic [COUNT_BITS-1:0]  cur_cnt;
   logic [HEAP_BITS-1:0]   parent;
   logic [NODE_BITS-1:0]   lchild;
   logic [NODE_BITS:0]     rchild;
   logic [WW-1:0]          sum;
   logic [LEN_BITS-1:0]    walk_len;
   logic [MAX_CODE_LEN-1:0] walk_code;

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign scan_sym  = {~i_ff[SYM_BITS-1], i_ff[SYM_BITS-2:0]};
   assign parent    = (pos_ff - 1'b1) >> 1;
   assign lchild    = {pos_ff, 1'b1};
   assign rchild    = {1'b0, lchild} + 1'b1;
   assign sum       = wn_ff + wgt_rdata;
   assign walk_len  = walk_rdata[WALK_W-1:MAX_CODE_LEN];
   assign walk_code = walk_rdata[MAX_CODE_LEN-1:0];

   always_comb begin
      state_in     = state_ff;
      sym_in       = sym_ff;
      i_in         = i_ff;
      leaves_in    = leaves_ff;
      size_in      = size_ff;
      next_in      = next_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cand_in      = cand_ff;
      selnode_in   = selnode_ff;
      wr_in        = wr_ff;
      wn_in        = wn_ff;
      selw_in      = selw_ff;
      pos_in       = pos_ff;
      selpos_in    = selpos_ff;
      sel_in       = sel_ff;
      second_in    = second_ff;
      phase_in     = phase_ff;
      wlen_in      = wlen_ff;
      wcode_in     = wcode_ff;
      cnt_vld_in   = cnt_vld_ff;
      tab_vld_in   = tab_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_found_in = rsp_found_ff;
      rsp_lc_in    = rsp_lc_ff;
      cur_cnt      = '0;

      cnt_we  = 1'b0; cnt_waddr  = '0; cnt_wdata  = '0; cnt_raddr  = '0;
      heap_we = 1'b0; heap_waddr = '0; heap_wdata = '0; heap_raddr = '0;
      wgt_we  = 1'b0; wgt_waddr  = '0; wgt_wdata  = '0; wgt_raddr  = '0;
      kids_we = 1'b0; kids_waddr = '0; kids_wdata = '0; kids_raddr = '0;
      lsym_we = 1'b0; lsym_waddr = '0; lsym_wdata = '0; lsym_raddr = '0;
      walk_we = 1'b0; walk_waddr = '0; walk_wdata = '0; walk_raddr = '0;
      tab_we  = 1'b0; tab_waddr  = '0; tab_wdata  = '0; tab_raddr  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sym_in = req_chan.symbol;
               unique case (req_chan.op)
                  OP_CLEAR:  state_in = S_CLR;
                  OP_COUNT:  state_in = S_CNT_RD;
                  OP_ENCODE: state_in = S_ENC_RD;
                  OP_BUILD: begin
                     tab_vld_in = '0;
                     size_in    = '0;
                     leaves_in  = '0;
                     i_in       = '0;
                     phase_in   = 1'b0;
                     state_in   = S_SCAN_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CLR: begin
            cnt_vld_in   = '0;
            rsp_valid_in = 1'b1;
            rsp_code_in  = '0;
            rsp_len_in   = '0;
            rsp_found_in = 1'b0;
            rsp_lc_in    = '0;
            state_in     = S_IDLE;
         end
         S_CNT_RD: begin
            cnt_raddr = sym_ff;
            state_in  = S_CNT_WR;
         end
         S_CNT_WR: begin
            cur_cnt   = cnt_vld_ff[sym_ff] ? cnt_rdata : '0;
            cnt_we    = 1'b1;
            cnt_waddr = sym_ff;
            cnt_wdata = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
            cnt_vld_in[sym_ff] = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_code_in  = '0;
            rsp_len_in   = '0;
            rsp_found_in = 1'b0;
            rsp_lc_in    = '0;
            state_in     = S_IDLE;
         end
         S_ENC_RD: begin
            tab_raddr = sym_ff;
            state_in  = S_ENC_OUT;
         end
         S_ENC_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_lc_in    = '0;
            rsp_found_in = tab_vld_ff[sym_ff];
            rsp_code_in  = tab_vld_ff[sym_ff] ?
                           CODE_BITS'(tab_rdata[MAX_CODE_LEN-1:0]) : '0;
            rsp_len_in   = tab_vld_ff[sym_ff] ?
                           OUT_LEN_BITS'(tab_rdata[WALK_W-1:MAX_CODE_LEN]) : '0;
            state_in     = S_IDLE;
         end
         S_SCAN_RD: begin
            cnt_raddr = scan_sym;
            state_in  = S_SCAN_CK;
         end
         S_SCAN_CK: begin
            cur_cnt = cnt_vld_ff[scan_sym] ? cnt_rdata : '0;
            if (cur_cnt != '0) begin
               wgt_we     = 1'b1;
               wgt_waddr  = leaves_ff;
               wgt_wdata  = WW'(cur_cnt);
               lsym_we    = 1'b1;
               lsym_waddr = leaves_ff[HEAP_BITS-1:0];
               lsym_wdata = scan_sym;
               n_in       = leaves_ff;
               wn_in      = WW'(cur_cnt);
               pos_in     = size_ff[HEAP_BITS-1:0];
               size_in    = size_ff + 1'b1;
               leaves_in  = leaves_ff + 1'b1;
               state_in   = S_P_CHK;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (phase_ff) begin
               state_in = S_MERGE;
            end else if (&i_ff[SYM_BITS-1:0]) begin
               next_in  = leaves_ff;
               state_in = S_MERGE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_P_CHK: begin
            if (pos_ff == '0) begin
               heap_we    = 1'b1;
               heap_waddr = '0;
               heap_wdata = n_ff;
               state_in   = S_NEXT;
            end else begin
               heap_raddr = parent;
               state_in   = S_P_RDH;
            end
         end
         S_P_RDH: begin
            cand_in   = heap_rdata;
            wgt_raddr = heap_rdata;
            state_in  = S_P_RDW;
         end
         S_P_RDW: begin
            heap_we    = 1'b1;
            heap_waddr = pos_ff;
            if (wgt_rdata > wn_ff) begin
               heap_wdata = cand_ff;
               pos_in     = parent;
               state_in   = S_P_CHK;
            end else begin
               heap_wdata = n_ff;
               state_in   = S_NEXT;
            end
         end
         S_MERGE: begin
            if (size_ff > NODE_BITS'(1)) begin
               second_in = 1'b0;
               state_in  = S_Q_RD0;
            end else if (leaves_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = '0;
               rsp_len_in   = '0;
               rsp_found_in = 1'b0;
               rsp_lc_in    = '0;
               state_in     = S_IDLE;
            end else begin
               state_in = S_W_INIT;
            end
         end
         S_Q_RD0: begin
            heap_raddr = '0;
            state_in   = S_Q_TOP;
         end
         S_Q_TOP: begin
            if (second_ff) begin
               b_in = heap_rdata;
            end else begin
               a_in = heap_rdata;
            end
            size_in    = size_ff - 1'b1;
            heap_raddr = HEAP_BITS'(size_ff - 1'b1);
            state_in   = S_Q_LAST;
         end
         S_Q_LAST: begin
            n_in      = heap_rdata;
            wgt_raddr = heap_rdata;
            state_in  = S_Q_LASTW;
         end
         S_Q_LASTW: begin
            wn_in    = wgt_rdata;
            pos_in   = '0;
            state_in = S_D_CHK;
         end
         S_D_CHK: begin
            sel_in  = 1'b0;
            selw_in = wn_ff;
            if (lchild >= size_ff) begin
               heap_we    = 1'b1;
               heap_waddr = pos_ff;
               heap_wdata = n_ff;
               state_in   = S_Q_DONE;
            end else begin
               heap_raddr = lchild[HEAP_BITS-1:0];
               state_in   = S_D_RDL;
            end
         end
         S_D_RDL: begin
            cand_in   = heap_rdata;
            wgt_raddr = heap_rdata;
            state_in  = S_D_RDLW;
         end
         S_D_RDLW: begin
            if (wgt_rdata < wn_ff) begin
               sel_in     = 1'b1;
               selnode_in = cand_ff;
               selw_in    = wgt_rdata;
               selpos_in  = lchild[HEAP_BITS-1:0];
            end
            if (rchild < {1'b0, size_ff}) begin
               heap_raddr = rchild[HEAP_BITS-1:0];
               state_in   = S_D_RDR;
            end else begin
               state_in = S_D_MOVE;
            end
         end
         S_D_RDR: begin
            cand_in   = heap_rdata;
            wgt_raddr = heap_rdata;
            state_in  = S_D_RDRW;
         end
         S_D_RDRW: begin
            if (wgt_rdata < selw_ff) begin
               sel_in     = 1'b1;
               selnode_in = cand_ff;
               selw_in    = wgt_rdata;
               selpos_in  = rchild[HEAP_BITS-1:0];
            end
            state_in = S_D_MOVE;
         end
         S_D_MOVE: begin
            heap_we    = 1'b1;
            heap_waddr = pos_ff;
            if (sel_ff) begin
               heap_wdata = selnode_ff;
               pos_in     = selpos_ff;
               state_in   = S_D_CHK;
            end else begin
               heap_wdata = n_ff;
               state_in   = S_Q_DONE;
            end
         end
         S_Q_DONE: begin
            if (second_ff) begin
               state_in = S_M_RDA;
            end else begin
               second_in = 1'b1;
               state_in  = S_Q_RD0;
            end
         end
         S_M_RDA: begin
            wgt_raddr = a_ff;
            state_in  = S_M_WA;
         end
         S_M_WA: begin
            wn_in     = wgt_rdata;
            wgt_raddr = b_ff;
            state_in  = S_M_WB;
         end
         S_M_WB: begin
            wgt_we     = 1'b1;
            wgt_waddr  = next_ff;
            wgt_wdata  = sum;
            kids_we    = 1'b1;
            kids_waddr = next_ff;
            kids_wdata = {a_ff, b_ff};
            n_in       = next_ff;
            wn_in      = sum;
            pos_in     = size_ff[HEAP_BITS-1:0];
            size_in    = size_ff + 1'b1;
            next_in    = next_ff + 1'b1;
            phase_in   = 1'b1;
            state_in   = S_P_CHK;
         end
         S_W_INIT: begin
            walk_we    = 1'b1;
            walk_waddr = next_ff - 1'b1;
            walk_wdata = '0;
            i_in       = next_ff - 1'b1;
            state_in   = S_W_CHK;
         end
         S_W_CHK: begin
            if (i_ff < leaves_ff) begin
               i_in     = '0;
               state_in = S_T_CHK;
            end else begin
               kids_raddr = i_ff;
               walk_raddr = i_ff;
               state_in   = S_W_RD;
            end
         end
         S_W_RD: begin
            walk_we    = 1'b1;
            walk_waddr = kids_rdata[2*NODE_BITS-1:NODE_BITS];
            walk_wdata = {walk_len + 1'b1, walk_code << 1};
            wr_in      = kids_rdata[NODE_BITS-1:0];
            wlen_in    = walk_len + 1'b1;
            wcode_in   = (walk_code << 1) | MAX_CODE_LEN'(1);
            state_in   = S_W_WR2;
         end
         S_W_WR2: begin
            walk_we    = 1'b1;
            walk_waddr = wr_ff;
            walk_wdata = {wlen_ff, wcode_ff};
            i_in       = i_ff - 1'b1;
            state_in   = S_W_CHK;
         end
         S_T_CHK: begin
            if (i_ff == leaves_ff) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = '0;
               rsp_len_in   = '0;
               rsp_found_in = 1'b0;
               rsp_lc_in    = leaves_ff;
               state_in     = S_IDLE;
            end else begin
               lsym_raddr = i_ff[HEAP_BITS-1:0];
               walk_raddr = i_ff;
               state_in   = S_T_WR;
            end
         end
         S_T_WR: begin
            if (walk_len <= LEN_BITS'(MAX_CODE_LEN)) begin
               tab_we     = 1'b1;
               tab_waddr  = lsym_rdata;
               tab_wdata  = walk_rdata;
               tab_vld_in[lsym_rdata] = 1'b1;
            end
            i_in     = i_ff + 1'b1;
            state_in = S_T_CHK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_vld_ff   <= '0;
         tab_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_vld_ff   <= cnt_vld_in;
         tab_vld_ff   <= tab_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      i_ff         <= i_in;
      leaves_ff    <= leaves_in;
      size_ff      <= size_in;
      next_ff      <= next_in;
      n_ff         <= n_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      cand_ff      <= cand_in;
      selnode_ff   <= selnode_in;
      wr_ff        <= wr_in;
      wn_ff        <= wn_in;
      selw_ff      <= selw_in;
      pos_ff       <= pos_in;
      selpos_ff    <= selpos_in;
      sel_ff       <= sel_in;
      second_ff    <= second_in;
      phase_ff     <= phase_in;
      wlen_ff      <= wlen_in;
      wcode_ff     <= wcode_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_found_ff <= rsp_found_in;
      rsp_lc_ff    <= rsp_lc_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.code        = rsp_code_ff;
   assign rsp_chan.code_length = rsp_len_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.leaf_count  = rsp_lc_ff;

   hcb_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_SYM)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
   );

   hcb_ram #(.WIDTH(NODE_BITS), .DEPTH(NUM_SYM)) u_heap_ram (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_waddr), .wr_data(heap_wdata),
      .rd_addr(heap_raddr), .rd_data(heap_rdata)
   );

   hcb_ram #(.WIDTH(WW), .DEPTH(NUM_NODE)) u_wgt_ram (
      .clock(clock), .wr_en(wgt_we), .wr_addr(wgt_waddr), .wr_data(wgt_wdata),
      .rd_addr(wgt_raddr), .rd_data(wgt_rdata)
   );

   hcb_ram #(.WIDTH(2*NODE_BITS), .DEPTH(NUM_NODE)) u_kids_ram (
      .clock(clock), .wr_en(kids_we), .wr_addr(kids_waddr), .wr_data(kids_wdata),
      .rd_addr(kids_raddr), .rd_data(kids_rdata)
   );

   hcb_ram #(.WIDTH(SYM_BITS), .DEPTH(NUM_SYM)) u_lsym_ram (
      .clock(clock), .wr_en(lsym_we), .wr_addr(lsym_waddr), .wr_data(lsym_wdata),
      .rd_addr(lsym_raddr), .rd_data(lsym_rdata)
   );

   hcb_ram #(.WIDTH(WALK_W), .DEPTH(NUM_NODE)) u_walk_ram (
      .clock(clock), .wr_en(walk_we), .wr_addr(walk_waddr), .wr_data(walk_wdata),
      .rd_addr(walk_raddr), .rd_data(walk_rdata)
   );

   hcb_ram #(.WIDTH(WALK_W), .DEPTH(NUM_SYM)) u_tab_ram (
      .clock(clock), .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(tab_wdata),
      .rd_addr(tab_raddr), .rd_data(tab_rdata)
   );

endmodule

`default_nettype wire

// ===== tb/huffman_code_builder_encoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder_encoder_unit_tb
// Drives count, build, encode and clear requests into the code builder with
// random idling and back pressure on both channels. A behavioral Huffman
// builder predicts each result; results are compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_builder_encoder_unit_tb;
   import hcb_pkg::*;

   typedef struct packed {
      logic [CODE_BITS-1:0]    code;
      logic [OUT_LEN_BITS-1:0] code_length;
      logic                    found;
      logic [LC_BITS-1:0]      leaf_count;
   } code_rsp_type;

   logic clock;
   logic reset;

   hcb_req_if req_chan ();
   hcb_rsp_if rsp_chan ();

   huffman_code_builder_encoder_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   code_rsp_type expected_codes[$];
   int        mismatches;
   bit        failed;
   int        sent_count;
   int        send_idle_pct;
   int        recv_idle_pct;
   int        recv_hold_cycles;

   // behavioral state of the block
   logic [DEF_COUNT_BITS-1:0] sym_counts[NUM_SYM];
   bit                        tab_valid[NUM_SYM];
   int                        tab_len[NUM_SYM];
   longint unsigned           tab_code[NUM_SYM];
   longint unsigned           node_wt[NUM_NODE];
   int                        node_l[NUM_NODE];
   int                        node_r[NUM_NODE];
   int                        heap[NUM_SYM];
   int                        heap_len;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end

   function automatic void heap_sift_up(int i);
      int p;
      int t;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (node_wt[heap[p]] > node_wt[heap[i]]) begin
            t = heap[p];
            heap[p] = heap[i];
            heap[i] = t;
            i = p;
         end else begin
            break;
         end
      end
   endfunction

   function automatic int heap_pop_min();
      int top;
      int i;
      int s;
      int t;
      top = heap[0];
      heap_len--;
      heap[0] = heap[heap_len];
      i = 0;
      forever begin
         s = i;
         if (2*i+1 < heap_len && node_wt[heap[2*i+1]] < node_wt[heap[s]]) s = 2*i+1;
         if (2*i+2 < heap_len && node_wt[heap[2*i+2]] < node_wt[heap[s]]) s = 2*i+2;
         if (s == i) break;
         t = heap[i];
         heap[i] = heap[s];
         heap[s] = t;
         i = s;
      end
      return top;
   endfunction

   function automatic int build_code_table();
      int              leaves;
      int              next;
      int              a;
      int              b;
      int              s;
      int              leaf_sym[NUM_SYM];
      longint unsigned walk_code[NUM_NODE];
      int              walk_len[NUM_NODE];
      leaves = 0;
      heap_len = 0;
      for (int i = 0; i < NUM_SYM; i++) begin
         tab_valid[i] = 1'b0;
         tab_len[i] = 0;
         tab_code[i] = 0;
      end
      for (int i = 0; i < NUM_SYM; i++) begin
         s = (i + 128) % 256;
         if (sym_counts[s] != 0) begin
            node_wt[leaves] = sym_counts[s];
            leaf_sym[leaves] = s;
            heap[heap_len] = leaves;
            heap_len++;
            heap_sift_up(heap_len - 1);
            leaves++;
         end
      end
      if (leaves == 0) return 0;
      next = leaves;
      while (heap_len > 1) begin
         a = heap_pop_min();
         b = heap_pop_min();
         node_wt[next] = node_wt[a] + node_wt[b];
         node_l[next] = a;
         node_r[next] = b;
         heap[heap_len] = next;
         heap_len++;
         heap_sift_up(heap_len - 1);
         next++;
      end
      walk_code[next-1] = 0;
      walk_len[next-1] = 0;
      for (int i = next - 1; i >= leaves; i--) begin
         walk_code[node_l[i]] = walk_code[i] << 1;
         walk_len[node_l[i]] = walk_len[i] + 1;
         walk_code[node_r[i]] = (walk_code[i] << 1) | 1;
         walk_len[node_r[i]] = walk_len[i] + 1;
      end
      for (int i = 0; i < leaves; i++) begin
         if (walk_len[i] <= DEF_MAX_CODE_LEN) begin
            tab_valid[leaf_sym[i]] = 1'b1;
            tab_len[leaf_sym[i]] = walk_len[i];
            tab_code[leaf_sym[i]] = walk_code[i];
         end
      end
      return leaves;
   endfunction

   function automatic code_rsp_type predict_code(op_type op, logic [SYM_BITS-1:0] sym);
      code_rsp_type r;
      r = '0;
      case (op)
         OP_CLEAR: begin
            for (int i = 0; i < NUM_SYM; i++) sym_counts[i] = '0;
         end
         OP_COUNT: begin
            if (sym_counts[sym] != '1) sym_counts[sym] = sym_counts[sym] + 1'b1;
         end
         OP_BUILD: begin
            r.leaf_count = LC_BITS'(build_code_table());
         end
         default: begin
            if (tab_valid[sym]) begin
               r.found = 1'b1;
               r.code_length = OUT_LEN_BITS'(tab_len[sym]);
               r.code = CODE_BITS'(tab_code[sym]);
            end
         end
      endcase
      return r;
   endfunction

   task automatic send_req(op_type op, logic [SYM_BITS-1:0] sym);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.op     <= op;
      req_chan.symbol <= sym;
      do @(posedge clock); while (!req_chan.ready);
      expected_codes.insert(expected_codes.size(), predict_code(op, sym));
      sent_count++;
   endtask

   task automatic drain_codes();
      @(posedge clock);
      req_chan.valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // receiver: random stalls plus an optional long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (recv_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            recv_hold_cycles--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      code_rsp_type exp_r;
      code_rsp_type got_r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_r.code        = rsp_chan.code;
         got_r.code_length = rsp_chan.code_length;
         got_r.found       = rsp_chan.found;
         got_r.leaf_count  = rsp_chan.leaf_count;
         if (expected_codes.size() == 0) begin
            failed = 1'b1;
            if (mismatches < 10) $display("unexpected result %h", got_r);
            mismatches++;
         end else begin
            exp_r = expected_codes.pop_front();
            if (got_r !== exp_r) begin
               failed = 1'b1;
               if (mismatches < 10)
                  $display("mismatch: code %h/%h len %0d/%0d found %0d/%0d lc %0d/%0d",
                           exp_r.code, got_r.code, exp_r.code_length, got_r.code_length,
                           exp_r.found, got_r.found, exp_r.leaf_count, got_r.leaf_count);
               mismatches++;
            end
         end
      end
   end

   task automatic test_empty_table();
      send_req(OP_ENCODE, 8'h00);
      send_req(OP_ENCODE, 8'hFF);
      send_req(OP_BUILD, 8'h00);
      send_req(OP_ENCODE, 8'h80);
      drain_codes();
   endtask

   task automatic test_lone_symbol();
      send_req(OP_CLEAR, 8'hFF);
      repeat (3) send_req(OP_COUNT, 8'h80);
      send_req(OP_BUILD, 8'h5A);
      send_req(OP_ENCODE, 8'h80);
      send_req(OP_ENCODE, 8'h7F);
      drain_codes();
   endtask

   task automatic test_extreme_symbols();
      send_req(OP_CLEAR, 8'h00);
      send_req(OP_COUNT, 8'h00);
      send_req(OP_COUNT, 8'hFF);
      send_req(OP_COUNT, 8'h7F);
      send_req(OP_COUNT, 8'h7F);
      send_req(OP_COUNT, 8'h80);
      send_req(OP_COUNT, 8'h01);
      send_req(OP_BUILD, 8'hFF);
      send_req(OP_ENCODE, 8'h00);
      send_req(OP_ENCODE, 8'hFF);
      send_req(OP_ENCODE, 8'h7F);
      send_req(OP_ENCODE, 8'h80);
      send_req(OP_ENCODE, 8'h01);
      // table survives a clear
      send_req(OP_CLEAR, 8'h00);
      send_req(OP_ENCODE, 8'h7F);
      send_req(OP_BUILD, 8'h00);
      send_req(OP_ENCODE, 8'h7F);
      drain_codes();
   endtask

   task automatic test_deep_tree();
      int f0;
      int f1;
      int t;
      f0 = 1;
      f1 = 1;
      send_req(OP_CLEAR, 8'h00);
      for (int s = 0; s < 9; s++) begin
         repeat (f0) send_req(OP_COUNT, 8'(s * 21));
         t = f0 + f1;
         f0 = f1;
         f1 = t;
      end
      send_req(OP_BUILD, 8'h00);
      for (int s = 0; s < 9; s++) send_req(OP_ENCODE, 8'(s * 21));
      drain_codes();
   endtask

   task automatic test_back_pressure();
      recv_hold_cycles = 400;
      for (int i = 0; i < 24; i++) send_req(OP_COUNT, 8'($urandom_range(255)));
      send_req(OP_BUILD, 8'h00);
      for (int i = 0; i < 8; i++) send_req(OP_ENCODE, 8'($urandom_range(255)));
      drain_codes();
   endtask

   task automatic test_full_alphabet();
      send_req(OP_CLEAR, 8'h00);
      for (int s = 0; s < NUM_SYM; s++) send_req(OP_COUNT, 8'(s));
      send_req(OP_BUILD, 8'h00);
      for (int i = 0; i < 16; i++) send_req(OP_ENCODE, 8'($urandom_range(255)));
      drain_codes();
   endtask

   task automatic test_random_sessions(int target);
      int start;
      int alpha;
      int base;
      int span;
      start = sent_count;
      while (sent_count - start < target) begin
         if ($urandom_range(9) == 0) begin
            send_req(op_type'($urandom_range(3)), 8'($urandom_range(255)));
         end else begin
            if ($urandom_range(3) != 0) send_req(OP_CLEAR, 8'($urandom_range(255)));
            alpha = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            base = $urandom_range(255);
            span = $urandom_range(1, 3);
            repeat ($urandom_range(1, 30))
               send_req(OP_COUNT, 8'(base + span * $urandom_range(alpha - 1)));
            send_req(OP_BUILD, 8'($urandom_range(255)));
            repeat ($urandom_range(2, 6))
               send_req(OP_ENCODE, 8'(base + span * $urandom_range(alpha - 1)));
            send_req(OP_ENCODE, 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.op     = OP_CLEAR;
      req_chan.symbol = '0;
      mismatches = 0;
      failed = 1'b0;
      sent_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold_cycles = 0;
      for (int i = 0; i < NUM_SYM; i++) begin
         sym_counts[i] = '0;
         tab_valid[i] = 1'b0;
         tab_len[i] = 0;
         tab_code[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 17;
      recv_idle_pct = 53;
      test_empty_table();
      test_lone_symbol();
      test_extreme_symbols();
      test_deep_tree();
      test_back_pressure();
      test_random_sessions(60);
      drain_codes();

      send_idle_pct = 53;
      recv_idle_pct = 17;
      test_full_alphabet();
      test_random_sessions(60);
      drain_codes();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_sessions(60);
      drain_codes();

      if (!failed && mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/hcb_pkg.sv
src/hcb_if.sv
src/hcb_ram.sv
src/huffman_code_builder_encoder_unit.sv
tb/huffman_code_builder_encoder_unit_tb.sv
